@@ rtl/sv39_page_table_walker_macros.svh @@
// Assertion macros for the Sv39 page table walker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH
`ifndef ASSERT_OFF
// Check held off while reset is asserted.
`define SV39_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds during reset.
`define SV39_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SV39_ASSERT(lbl, clk, rst_n, prop, msg)
`define SV39_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/sv39_ptw_pkg.sv @@
// Shared types, codes and constants of the Sv39 page table walker.
// Used by the walk controller and the top level; no dependencies.
package sv39_ptw_pkg;

    localparam int STORE_PAGES_DEF   = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PPN_W             = 44;
    localparam int PAGE_OFS_W        = 12;
    localparam int BASE_W            = 56;
    localparam int VA_W              = 64;
    localparam int VA_LIMIT_W        = 38;
    localparam int WADDR_W           = 13;
    localparam int PTE_W             = 64;
    localparam int ROOT_W            = 4;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 44;
    localparam int S_TDATA_W         = 144;
    localparam int M_TDATA_W         = 64;

    // PTE flag positions
    localparam int PTE_V   = 0;
    localparam int PTE_R   = 1;
    localparam int PTE_X   = 3;
    localparam int PTE_U   = 4;
    localparam int PTE_PPN = 10;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XLATE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_PAGE  = 1'b0,
        CFG_STORE_BASE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_VA_LARGE = 3'd1,
        STAT_INVALID  = 3'd2,
        STAT_NO_USER  = 3'd3,
        STAT_OUTSIDE  = 3'd4,
        STAT_WRITE    = 3'd5
    } status_t;

    typedef struct packed {
        logic                   opcode;
        logic [WADDR_W-1:0]     word_addr;
        logic [PTE_W-1:0]       word_data;
        logic [VA_W-1:0]        virt_addr;
    } req_t;

    typedef struct packed {
        logic [ROOT_W-1:0]      root_page;
        logic [PPN_W-1:0]       store_base_ppn;
    } cfg_t;

    typedef struct packed {
        logic [BASE_W-1:0]      phys_page_base;
        logic [1:0]             leaf_level;
        status_t                status;
    } res_t;

    function automatic logic [PPN_W-1:0] pte_ppn(input logic [PTE_W-1:0] pte);
        return pte[PTE_PPN +: PPN_W];
    endfunction

endpackage

@@ rtl/sv39_ptw_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// Stand-alone; holds the page table store.
module sv39_ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sv39_ptw_walk.sv @@
// Walk controller: clearing pass, table writes and the three-level lookup.
// Depends on sv39_ptw_pkg, sv39_ptw_ram and the assertion macro header.
`include "sv39_page_table_walker_macros.svh"
module sv39_ptw_walk #(
    parameter int STORE_PAGES = sv39_ptw_pkg::STORE_PAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sv39_ptw_pkg::req_t  in_req,
    input  sv39_ptw_pkg::cfg_t  cfg,
    output logic                res_valid,
    input  logic                res_ready,
    output sv39_ptw_pkg::res_t  res
);
    import sv39_ptw_pkg::*;

    localparam int WORDS  = STORE_PAGES * ENTRIES_PER_TABLE;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int PG_W   = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int VPN_LO_W = 2 * IDX_W;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic [1:0]             level_reg, level_next;
    logic [VPN_LO_W-1:0]    vpn_lo_reg, vpn_lo_next;
    res_t                   res_reg, res_next;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [PTE_W-1:0]       wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [PTE_W-1:0]       pte;

    logic [31:0]            waddr_ext;
    logic [31:0]            root_ext;
    logic [PG_W+IDX_W-1:0]  root_word;
    logic [PPN_W-1:0]       ppn;
    logic [PPN_W-1:0]       ppn_diff;
    logic                   ppn_inside;
    logic [IDX_W-1:0]       next_idx;
    logic [PG_W+IDX_W-1:0]  next_word;
    logic                   is_leaf;

    sv39_ptw_ram #(
        .WIDTH (PTE_W),
        .DEPTH (WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pte)
    );

    assign waddr_ext  = 32'(in_req.word_addr);
    assign root_ext   = 32'(cfg.root_page);
    assign root_word  = {root_ext[PG_W-1:0], in_req.virt_addr[30 +: IDX_W]};
    assign ppn        = pte_ppn(pte);
    assign ppn_diff   = ppn - cfg.store_base_ppn;
    assign ppn_inside = (ppn >= cfg.store_base_ppn) && (ppn_diff < PPN_W'(STORE_PAGES));
    assign next_idx   = (level_reg == 2'd2) ? vpn_lo_reg[IDX_W +: IDX_W]
                                            : vpn_lo_reg[IDX_W-1:0];
    assign next_word  = {ppn_diff[PG_W-1:0], next_idx};
    assign is_leaf    = (level_reg == 2'd0) || (pte[PTE_X:PTE_R] != '0);

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        level_next  = level_reg;
        vpn_lo_next = vpn_lo_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = clr_reg;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = root_word[ADDR_W-1:0];
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = S_DONE;
                    res_next   = '{phys_page_base: '0, leaf_level: 2'd0, status: STAT_OK};
                    if (in_req.opcode == OP_WRITE) begin
                        // drop writes beyond the store, still acknowledge
                        wr_en           = (waddr_ext < 32'(WORDS));
                        wr_addr         = waddr_ext[ADDR_W-1:0];
                        wr_data         = in_req.word_data;
                        res_next.status = STAT_WRITE;
                    end else if (in_req.virt_addr[VA_W-1:VA_LIMIT_W] != '0) begin
                        res_next.status = STAT_VA_LARGE;
                    end else if (root_ext >= 32'(STORE_PAGES)) begin
                        res_next.status = STAT_OUTSIDE;
                    end else begin
                        rd_en       = 1'b1;
                        level_next  = 2'd2;
                        vpn_lo_next = in_req.virt_addr[PAGE_OFS_W +: VPN_LO_W];
                        state_next  = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                state_next = S_DONE;
                if (!pte[PTE_V]) begin
                    res_next.status = STAT_INVALID;
                end else if (is_leaf) begin
                    if (!pte[PTE_U]) begin
                        res_next.status = STAT_NO_USER;
                    end else begin
                        res_next.phys_page_base = {ppn, PAGE_OFS_W'(0)};
                        res_next.leaf_level     = level_reg;
                        res_next.status         = STAT_OK;
                    end
                end else if (!ppn_inside) begin
                    res_next.status = STAT_OUTSIDE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = next_word[ADDR_W-1:0];
                    level_next = level_reg - 2'd1;
                    state_next = S_LOOKUP;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            level_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        vpn_lo_reg <= vpn_lo_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

    `SV39_ASSERT(a_accept_leaves_idle, aclk, aresetn, (in_valid && in_ready) |=> (state_reg != S_IDLE), "accepted request left walker idle")
    `SV39_ASSERT(a_read_is_consumed, aclk, aresetn, rd_en |=> (state_reg == S_LOOKUP), "table read issued without a lookup to consume it")
    `SV39_ASSERT(a_clear_ends, aclk, aresetn, ((state_reg == S_CLEAR) && (clr_reg == ADDR_W'(WORDS - 1))) |=> (state_reg == S_IDLE), "clearing pass did not finish at the last word")

endmodule

@@ rtl/sv39_page_table_walker.sv @@
// Top level of the Sv39 page table walker: ports, configuration and output register.
// Depends on sv39_ptw_pkg, sv39_ptw_walk and the assertion macro header.
//
//  channel | direction | tdata / data                          | tuser
//  s_      | in        | word_addr, word_data, virt_addr       | opcode
//  m_      | out       | phys_page_base, leaf_level            | status
//  cfg_    | in        | cfg_index selects register, cfg_data  | -
//
// A write request, or a translation refused before any table read, goes from
// acceptance into the walker's result register and then to the output register;
// a walk reads up to three table levels before the hand-over, each level waiting
// for the registered read of the single table store RAM. The next request is
// taken the cycle after the hand-over.
// After reset the store of STORE_PAGES * 512 words (8192 by default) is cleared
// one word a cycle; s_tready stays low until then, cfg writes are taken always.
// One request is in flight at a time; a result waiting on m_tready holds it.
`include "sv39_page_table_walker_macros.svh"
module sv39_page_table_walker #(
    parameter int STORE_PAGES = sv39_ptw_pkg::STORE_PAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [12:0] word_addr, [76:13] word_data, [140:77] virt_addr, [143:141] zero
    input  logic [sv39_ptw_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] opcode
    input  logic                                   s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [55:0] phys_page_base, [57:56] leaf_level, [63:58] zero
    output logic [sv39_ptw_pkg::M_TDATA_W-1:0]     m_tdata,
    // [2:0] status
    output logic [2:0]                             m_tuser,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sv39_ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sv39_ptw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sv39_ptw_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    req_t   in_req;
    res_t   res;
    logic   res_valid;
    logic   res_ready;
    logic   m_tvalid_reg, m_tvalid_next;
    res_t   out_reg;

    // unpack the request, lowest field first
    assign in_req.opcode    = s_tuser;
    assign in_req.word_addr = s_tdata[WADDR_W-1:0];
    assign in_req.word_data = s_tdata[WADDR_W +: PTE_W];
    assign in_req.virt_addr = s_tdata[WADDR_W+PTE_W +: VA_W];

    sv39_ptw_walk #(
        .STORE_PAGES (STORE_PAGES)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // configuration registers: always ready, decode by index
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROOT_PAGE:  cfg_next.root_page      = cfg_data[ROOT_W-1:0];
                CFG_STORE_BASE: cfg_next.store_base_ppn = cfg_data[PPN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // output register: take a new result whenever the slot is free or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // hold the payload until the next result is loaded
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - BASE_W - 2)'(0), out_reg.leaf_level, out_reg.phys_page_base};
    assign m_tuser  = out_reg.status;

    `SV39_ASSERT(a_root_write, aclk, aresetn, (cfg_valid && (cfg_index == CFG_ROOT_PAGE)) |=> (cfg_reg.root_page == $past(cfg_data[ROOT_W-1:0])), "root page register not loaded")
    `SV39_ASSERT(a_base_write, aclk, aresetn, (cfg_valid && (cfg_index == CFG_STORE_BASE)) |=> (cfg_reg.store_base_ppn == $past(cfg_data[PPN_W-1:0])), "store base register not loaded")
    `SV39_ASSERT(a_result_lands, aclk, aresetn, (res_valid && res_ready) |=> m_tvalid, "handed-over result not shown on the output")

endmodule
